// ===== design/scooter_telemetry_frame_decoder_macros.svh =====
// assertion macros for the scooter telemetry frame decoder
// included by the modules that carry concurrent checks; no dependencies
`ifndef SCOOTER_TELEMETRY_FRAME_DECODER_MACROS_SVH
`define SCOOTER_TELEMETRY_FRAME_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define STFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stfd same-cycle check failed");
`define STFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stfd next-cycle check failed");
`else
`define STFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define STFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/stfd_pkg.sv =====
// shared types and constants of the scooter telemetry frame decoder
// no dependencies
package stfd_pkg;

  localparam logic [7:0] HEADER_BYTE = 8'hAF;
  localparam logic [7:0] TYPE_LIVE   = 8'd0;
  localparam logic [7:0] TYPE_PRESET = 8'd1;

  localparam logic [1:0] KIND_LIVE    = 2'd0;
  localparam logic [1:0] KIND_PRESET  = 2'd1;
  localparam logic [1:0] KIND_IGNORED = 2'd2;

  // bytes 0..20 are the only ones the decode looks at
  localparam int STORE_BYTES = 21;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  gear_byte;
    logic [7:0]  charge;
    logic [15:0] speed;
    logic [15:0] voltage;
    logic [15:0] current_raw;
    logic [7:0]  temperature;
    logic [15:0] trip;
    logic [23:0] total;
    logic [23:0] presets;
    logic [31:0] now_ms;
  } desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ===== design/stfd_if.sv =====
// valid/ready channels of the frame decoder: byte input and result output
// depends on nothing but plain logic types
interface stfd_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic [31:0] now_ms;

  modport source (output valid, output data_byte, output last_byte, output now_ms,
                  input ready);
  modport sink (input valid, input data_byte, input last_byte, input now_ms,
                output ready);
endinterface

interface stfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic [8:0]         gear_level;
  logic [7:0]         charge_percent;
  logic [15:0]        speed_milli_kmh;
  logic [15:0]        voltage_decivolts;
  logic signed [15:0] current_centiamps;
  logic [7:0]         temperature_c;
  logic [15:0]        trip_decikm;
  logic [23:0]        total_decikm;
  logic signed [63:0] energy_micro_ws;
  logic [23:0]        speed_presets;
  logic [31:0]        notification_count;

  modport source (output valid, output frame_kind, output gear_level,
                  output charge_percent, output speed_milli_kmh,
                  output voltage_decivolts, output current_centiamps,
                  output temperature_c, output trip_decikm, output total_decikm,
                  output energy_micro_ws, output speed_presets,
                  output notification_count, input ready);
  modport sink (input valid, input frame_kind, input gear_level,
                input charge_percent, input speed_milli_kmh,
                input voltage_decivolts, input current_centiamps,
                input temperature_c, input trip_decikm, input total_decikm,
                input energy_micro_ws, input speed_presets,
                input notification_count, output ready);
endinterface

// ===== design/scooter_telemetry_frame_decoder.sv =====
// scooter telemetry frame decoder, top level
// depends on stfd_pkg, stfd_if, stfd_front, stfd_queue, stfd_back
//
// in_ch carries notification bytes, one item per byte, with last_byte on the
// final byte and now_ms giving the arrival time. out_ch gives one item per
// notification: its kind and all held ride values, energy and count.
// Bytes are taken at one per cycle as long as the two-entry notification
// queue has room; a notification of one byte is enough to fill an entry.
// The result passes the queue, then the back end goes straight to its
// output state for presets, ignored or first live frames, and via its
// multiply and accumulate states for live frames that add energy (the
// voltage*current product and the *elapsed-ms product take one registered
// multiplier stage each, then a saturating 64-bit add). The back end takes
// no new notification before out_ch has taken the last; while out_ch stalls
// the result stays put and the front takes bytes until the queue is full,
// then drops in_ch.ready. Synchronous reset clears position, held values,
// energy, time base, count and the queue; the frame byte store is left as is.
module scooter_telemetry_frame_decoder #(
  parameter int FRAME_LENGTH = 25
) (
  input logic        clk,
  input logic        rst_n,
  stfd_in_if.sink    in_ch,
  stfd_out_if.source out_ch
);
  import stfd_pkg::*;

  logic      push, pop;
  desc_t     push_desc, pop_desc;
  q_status_t q_status;

  stfd_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_status  (q_status),
    .push      (push),
    .push_desc (push_desc)
  );

  stfd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .pop_desc  (pop_desc),
    .q_status  (q_status)
  );

  stfd_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .pop_desc (pop_desc),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== design/stfd_front.sv =====
// front end: takes payload bytes, collects the frame and classifies it
// depends on stfd_pkg, stfd_if and the macro header
`include "scooter_telemetry_frame_decoder_macros.svh"

module stfd_front #(
  parameter int FRAME_LENGTH = 25
) (
  input  logic                clk,
  input  logic                rst_n,
  stfd_in_if.sink             in_ch,
  input  stfd_pkg::q_status_t q_status,
  output logic                push,
  output stfd_pkg::desc_t     push_desc
);
  import stfd_pkg::*;

  localparam int PW = $clog2(FRAME_LENGTH + 1);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LENGTH);
  localparam logic [PW-1:0] STORE_END = PW'(STORE_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic [7:0]    store_r [STORE_BYTES];
  logic [7:0]    cur [STORE_BYTES];
  logic          accept, room, ovf_after, frame_ok;
  logic [PW-1:0] pos_after;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign room        = pos_r < LAST_POS;
  assign pos_after   = room ? pos_r + PW'(1) : pos_r;
  assign ovf_after   = ovf_r | !room;

  // frame bytes as they stand once this item is written
  always_comb begin
    for (int i = 0; i < STORE_BYTES; i++) begin
      cur[i] = (room && pos_r == PW'(i)) ? in_ch.data_byte : store_r[i];
    end
  end

  assign frame_ok = !ovf_after && pos_after == LAST_POS && cur[0] == HEADER_BYTE;

  always_comb begin
    push_desc.kind = KIND_IGNORED;
    if (frame_ok && cur[1] == TYPE_LIVE) begin
      push_desc.kind = KIND_LIVE;
    end else if (frame_ok && cur[1] == TYPE_PRESET) begin
      push_desc.kind = KIND_PRESET;
    end
    push_desc.gear_byte   = cur[4];
    push_desc.charge      = cur[5];
    push_desc.speed       = {cur[6], cur[7]};
    push_desc.voltage     = {cur[10], cur[11]};
    push_desc.current_raw = {cur[12], cur[13]};
    push_desc.temperature = cur[14];
    push_desc.trip        = {cur[16], cur[17]};
    push_desc.total       = {cur[18], cur[19], cur[20]};
    push_desc.presets     = {cur[4], cur[5], cur[6]};
    push_desc.now_ms      = in_ch.now_ms;
  end

  assign push = accept && in_ch.last_byte;

  always_comb begin
    pos_nxt = pos_r;
    ovf_nxt = ovf_r;
    if (accept) begin
      if (in_ch.last_byte) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else begin
        pos_nxt = pos_after;
        ovf_nxt = ovf_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && pos_r < STORE_END) begin
      store_r[pos_r[STORE_AW-1:0]] <= in_ch.data_byte;
    end
  end

  `STFD_ASSERT_NOW(a_pos_bound, clk, rst_n, 1'b1, pos_r <= LAST_POS)
  `STFD_ASSERT_NOW(a_push_room, clk, rst_n, push, !q_status.full)
  `STFD_ASSERT_NEXT(a_last_clears, clk, rst_n, push, pos_r == '0 && !ovf_r)

endmodule

// ===== design/stfd_queue.sv =====
// two-entry queue of classified notifications between front and back
// depends on stfd_pkg
module stfd_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  stfd_pkg::desc_t     push_desc,
  input  logic                pop,
  output stfd_pkg::desc_t     pop_desc,
  output stfd_pkg::q_status_t q_status
);
  import stfd_pkg::*;

  localparam logic [QUEUE_AW:0] DEPTH_CNT = (QUEUE_AW + 1)'(QUEUE_DEPTH);

  desc_t               mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QUEUE_AW:0]   cnt_r, cnt_nxt;

  assign q_status.full  = cnt_r == DEPTH_CNT;
  assign q_status.empty = cnt_r == '0;
  assign pop_desc       = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = wr_r + QUEUE_AW'(1);
    end
    if (pop) begin
      rd_nxt = rd_r + QUEUE_AW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + (QUEUE_AW + 1)'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - (QUEUE_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_desc;
    end
  end

endmodule

// ===== design/stfd_back.sv =====
// back end: applies classified notifications to the held values,
// accumulates energy and presents the result; depends on stfd_pkg, stfd_if and the macro header
`include "scooter_telemetry_frame_decoder_macros.svh"

module stfd_back (
  input  logic                clk,
  input  logic                rst_n,
  input  stfd_pkg::q_status_t q_status,
  input  stfd_pkg::desc_t     pop_desc,
  output logic                pop,
  stfd_out_if.source          out_ch
);
  import stfd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic signed [63:0] E_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] E_MIN = {1'b1, {63{1'b0}}};

  typedef struct packed {
    logic [8:0]  gear;
    logic [7:0]  charge;
    logic [15:0] speed;
    logic [15:0] voltage;
    logic [15:0] current;
    logic [7:0]  temperature;
    logic [15:0] trip;
    logic [23:0] total;
    logic [23:0] presets;
  } held_t;

  logic [1:0]         state_r, state_nxt;
  held_t              held_r, held_nxt;
  logic [1:0]         kind_r, kind_nxt;
  logic signed [63:0] energy_r, energy_nxt;
  logic [31:0]        prev_r, prev_nxt;
  logic               known_r, known_nxt;
  logic [31:0]        count_r, count_nxt;
  logic [30:0]        pv_r, pv_nxt;
  logic [31:0]        dt_r, dt_nxt;
  logic               neg_r, neg_nxt;
  logic [62:0]        prod_r, prod_nxt;
  logic [14:0]        cur_mag;
  logic signed [64:0] sum;
  logic               live;

  // raw of 0x8000 and above means raw - 65535, i.e. raw + 1 in 16 bits
  assign cur_mag = pop_desc.current_raw[15] ? ~pop_desc.current_raw[14:0]
                                            : pop_desc.current_raw[14:0];
  assign live = pop_desc.kind == KIND_LIVE;
  assign pop  = state_r == ST_IDLE && !q_status.empty;

  assign sum = neg_r ? {energy_r[63], energy_r} - {2'b00, prod_r}
                     : {energy_r[63], energy_r} + {2'b00, prod_r};

  always_comb begin
    state_nxt  = state_r;
    held_nxt   = held_r;
    kind_nxt   = kind_r;
    energy_nxt = energy_r;
    prev_nxt   = prev_r;
    known_nxt  = known_r;
    count_nxt  = count_r;
    pv_nxt     = pv_r;
    dt_nxt     = dt_r;
    neg_nxt    = neg_r;
    prod_nxt   = prod_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          count_nxt = count_r + 32'd1;
          kind_nxt  = pop_desc.kind;
          state_nxt = ST_OUT;
          if (live) begin
            held_nxt.gear        = {1'b0, pop_desc.gear_byte} + 9'd1;
            held_nxt.charge      = pop_desc.charge;
            held_nxt.speed       = pop_desc.speed;
            held_nxt.voltage     = pop_desc.voltage;
            held_nxt.current     = pop_desc.current_raw[15] ?
                                   pop_desc.current_raw + 16'd1 : pop_desc.current_raw;
            held_nxt.temperature = pop_desc.temperature;
            held_nxt.trip        = pop_desc.trip;
            held_nxt.total       = pop_desc.total;
            prev_nxt             = pop_desc.now_ms;
            known_nxt            = 1'b1;
            // the first live frame sets the time base without adding energy
            if (known_r) begin
              pv_nxt    = 31'(pop_desc.voltage) * 31'(cur_mag);
              dt_nxt    = pop_desc.now_ms - prev_r;
              neg_nxt   = pop_desc.current_raw[15];
              state_nxt = ST_MUL;
            end
          end else if (pop_desc.kind == KIND_PRESET) begin
            held_nxt.presets = pop_desc.presets;
          end
        end
      end
      ST_MUL: begin
        prod_nxt  = 63'(pv_r) * 63'(dt_r);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (sum[64] != sum[63]) begin
          energy_nxt = sum[64] ? E_MIN : E_MAX;
        end else begin
          energy_nxt = sum[63:0];
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      held_r   <= '0;
      kind_r   <= KIND_IGNORED;
      energy_r <= '0;
      prev_r   <= '0;
      known_r  <= 1'b0;
      count_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      held_r   <= held_nxt;
      kind_r   <= kind_nxt;
      energy_r <= energy_nxt;
      prev_r   <= prev_nxt;
      known_r  <= known_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_r   <= pv_nxt;
    dt_r   <= dt_nxt;
    neg_r  <= neg_nxt;
    prod_r <= prod_nxt;
  end

  // held registers are frozen in ST_OUT, so the result can be read straight off them
  assign out_ch.valid              = state_r == ST_OUT;
  assign out_ch.frame_kind         = kind_r;
  assign out_ch.gear_level         = held_r.gear;
  assign out_ch.charge_percent     = held_r.charge;
  assign out_ch.speed_milli_kmh    = held_r.speed;
  assign out_ch.voltage_decivolts  = held_r.voltage;
  assign out_ch.current_centiamps  = $signed(held_r.current);
  assign out_ch.temperature_c      = held_r.temperature;
  assign out_ch.trip_decikm        = held_r.trip;
  assign out_ch.total_decikm       = held_r.total;
  assign out_ch.energy_micro_ws    = energy_r;
  assign out_ch.speed_presets      = held_r.presets;
  assign out_ch.notification_count = count_r;

  `STFD_ASSERT_NEXT(a_count_step, clk, rst_n, pop, count_r == $past(count_r) + 32'd1)
  `STFD_ASSERT_NEXT(a_energy_path, clk, rst_n, pop && live && known_r, state_r == ST_MUL)
  `STFD_ASSERT_NEXT(a_stall_holds, clk, rst_n, out_ch.valid && !out_ch.ready,
                    $stable(count_r) && $stable(energy_r) && $stable(held_r))

endmodule
